>>> rtl/sync_header_sum_checked_frame_parser_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef SYNC_HEADER_SUM_CHECKED_FRAME_PARSER_ASSERT_SVH
`define SYNC_HEADER_SUM_CHECKED_FRAME_PARSER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SHSCFP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define SHSCFP_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

>>> rtl/shscfp_pkg.sv
package shscfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    typedef enum logic [2:0] {
        POS_HDR0 = 3'd0,
        POS_HDR1 = 3'd1,
        POS_SPDX = 3'd2,
        POS_SPDY = 3'd3,
        POS_RSVD = 3'd4,
        POS_DSTL = 3'd5,
        POS_DSTH = 3'd6,
        POS_CSUM = 3'd7
    } pos_t;

    // speed_x in the low bits, as on the output bus
    typedef struct packed {
        logic        [15:0] distance;
        logic signed [7:0]  speed_y;
        logic signed [7:0]  speed_x;
    } result_t;

endpackage

>>> rtl/sync_header_sum_checked_frame_parser.sv
// Channel | Dir | Handshake         | Payload
// s_*     | in  | s_tvalid/s_tready | s_tdata[7:0] rx_byte
// m_*     | out | m_tvalid/m_tready | m_tdata speed_x, speed_y, distance
//
// One item per cycle while s_tready is high; a checksum match registers a result for m_*.
// rst_n clears the frame position, checksum, field registers and output valid flags.
// An output register plus one skid entry: s_tready drops only while the skid entry is full.
// Bytes with no result never wait on m_tready beyond that.
module sync_header_sum_checked_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] speed_x, [15:8] speed_y, [31:16] distance
);

    `include "sync_header_sum_checked_frame_parser_assert.svh"

    logic                s_acc;
    logic                res_valid;
    shscfp_pkg::result_t res;

    logic                out_valid_reg;
    logic                out_valid_next;
    shscfp_pkg::result_t out_data_reg;
    shscfp_pkg::result_t out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    shscfp_pkg::result_t skid_data_reg;
    shscfp_pkg::result_t skid_data_next;

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    shscfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_acc),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = skid_valid_reg;
            out_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        // skid is empty whenever an item is accepted
        if (res_valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SHSCFP_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg)
    `SHSCFP_ASSERT(a_stall_to_skid, clk, rst_n, (res_valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
    `SHSCFP_ASSERT(a_res_shows, clk, rst_n, res_valid |=> out_valid_reg)

endmodule

>>> rtl/shscfp_core.sv
module shscfp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output shscfp_pkg::result_t res
);

    `include "sync_header_sum_checked_frame_parser_assert.svh"

    shscfp_pkg::pos_t pos_reg;
    shscfp_pkg::pos_t pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       spdx_reg;
    logic [7:0]       spdx_next;
    logic [7:0]       spdy_reg;
    logic [7:0]       spdy_next;
    logic [7:0]       dstl_reg;
    logic [7:0]       dstl_next;
    logic [7:0]       dsth_reg;
    logic [7:0]       dsth_next;
    logic             csum_acc;
    logic             hdr1_bad;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_reg)
                shscfp_pkg::POS_HDR0:
                begin
                    pos_next = (rx_byte == shscfp_pkg::HDR_FIRST) ?
                               shscfp_pkg::POS_HDR1 : shscfp_pkg::POS_HDR0;
                end
                shscfp_pkg::POS_HDR1:
                begin
                    pos_next = (rx_byte == shscfp_pkg::HDR_SECOND) ?
                               shscfp_pkg::POS_SPDX : shscfp_pkg::POS_HDR0;
                end
                shscfp_pkg::POS_SPDX: pos_next = shscfp_pkg::POS_SPDY;
                shscfp_pkg::POS_SPDY: pos_next = shscfp_pkg::POS_RSVD;
                shscfp_pkg::POS_RSVD: pos_next = shscfp_pkg::POS_DSTL;
                shscfp_pkg::POS_DSTL: pos_next = shscfp_pkg::POS_DSTH;
                shscfp_pkg::POS_DSTH: pos_next = shscfp_pkg::POS_CSUM;
                default:              pos_next = shscfp_pkg::POS_HDR0;
            endcase
        end
    end

    always_comb
    begin
        sum_next  = sum_reg;
        spdx_next = spdx_reg;
        spdy_next = spdy_reg;
        dstl_next = dstl_reg;
        dsth_next = dsth_reg;
        res_valid = 1'b0;
        res.speed_x  = spdx_reg;
        res.speed_y  = spdy_reg;
        res.distance = {dsth_reg, dstl_reg};
        if (accept)
        begin
            case (pos_reg)
                shscfp_pkg::POS_HDR0:
                begin
                    if (rx_byte == shscfp_pkg::HDR_FIRST)
                    begin
                        sum_next = rx_byte;
                    end
                end
                shscfp_pkg::POS_HDR1:
                begin
                    if (rx_byte == shscfp_pkg::HDR_SECOND)
                    begin
                        sum_next = sum_reg + rx_byte;
                    end
                end
                shscfp_pkg::POS_CSUM:
                begin
                    res_valid = (sum_reg == rx_byte);
                end
                default:
                begin
                    sum_next = sum_reg + rx_byte;
                    case (pos_reg)
                        shscfp_pkg::POS_SPDX: spdx_next = rx_byte;
                        shscfp_pkg::POS_SPDY: spdy_next = rx_byte;
                        shscfp_pkg::POS_DSTL: dstl_next = rx_byte;
                        shscfp_pkg::POS_DSTH: dsth_next = rx_byte;
                        default:              spdx_next = spdx_reg;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= shscfp_pkg::POS_HDR0;
            sum_reg  <= 8'd0;
            spdx_reg <= 8'd0;
            spdy_reg <= 8'd0;
            dstl_reg <= 8'd0;
            dsth_reg <= 8'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            spdx_reg <= spdx_next;
            spdy_reg <= spdy_next;
            dstl_reg <= dstl_next;
            dsth_reg <= dsth_next;
        end
    end

    assign csum_acc = accept && (pos_reg == shscfp_pkg::POS_CSUM);
    assign hdr1_bad = accept && (pos_reg == shscfp_pkg::POS_HDR1) &&
                      (rx_byte != shscfp_pkg::HDR_SECOND);

    `SHSCFP_NEVER(a_res_only_at_csum, clk, rst_n, res_valid && !csum_acc)
    `SHSCFP_ASSERT(a_csum_returns, clk, rst_n, csum_acc |=> (pos_reg == shscfp_pkg::POS_HDR0))
    `SHSCFP_ASSERT(a_bad_hdr1, clk, rst_n, hdr1_bad |=> (pos_reg == shscfp_pkg::POS_HDR0))

endmodule

>>> test/tb_top.sv
module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 9;
    localparam int TARGET_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    class frame_scoreboard;
        shscfp_pkg::result_t pending_results[$];
        shscfp_pkg::pos_t    pos;
        logic [7:0]          sum;
        logic [7:0]          sx;
        logic [7:0]          sy;
        logic [7:0]          dist_lo;
        logic [7:0]          dist_hi;
        int                  mismatches;
        int                  unexpected;
        int                  checked;
        int                  predicted;

        function new();
            pos        = shscfp_pkg::POS_HDR0;
            sum        = '0;
            sx         = '0;
            sy         = '0;
            dist_lo    = '0;
            dist_hi    = '0;
            mismatches = 0;
            unexpected = 0;
            checked    = 0;
            predicted  = 0;
        endfunction

        // advance the frame tracker by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            shscfp_pkg::result_t r;
            case (pos)
                shscfp_pkg::POS_HDR0:
                begin
                    if (b == shscfp_pkg::HDR_FIRST)
                    begin
                        sum = b;
                        pos = shscfp_pkg::POS_HDR1;
                    end
                end
                shscfp_pkg::POS_HDR1:
                begin
                    if (b == shscfp_pkg::HDR_SECOND)
                    begin
                        sum = sum + b;
                        pos = shscfp_pkg::POS_SPDX;
                    end
                    else
                        pos = shscfp_pkg::POS_HDR0;
                end
                shscfp_pkg::POS_CSUM:
                begin
                    if (sum == b)
                    begin
                        r.speed_x  = sx;
                        r.speed_y  = sy;
                        r.distance = {dist_hi, dist_lo};
                        pending_results.push_back(r);
                        predicted++;
                    end
                    pos = shscfp_pkg::POS_HDR0;
                end
                default:
                begin
                    case (pos)
                        shscfp_pkg::POS_SPDX: sx      = b;
                        shscfp_pkg::POS_SPDY: sy      = b;
                        shscfp_pkg::POS_DSTL: dist_lo = b;
                        shscfp_pkg::POS_DSTH: dist_hi = b;
                        default:  ;
                    endcase
                    sum = sum + b;
                    pos = shscfp_pkg::pos_t'(pos + 3'd1);
                end
            endcase
        endfunction

        function void check_result(shscfp_pkg::result_t got);
            shscfp_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("unexpected result: sx=%0d sy=%0d dist=%0d",
                             got.speed_x, got.speed_y, got.distance);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.speed_x !== want.speed_x || got.speed_y !== want.speed_y ||
                got.distance !== want.distance)
            begin
                mismatches++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("mismatch: exp sx=%0d sy=%0d dist=%0d, got sx=%0d sy=%0d dist=%0d",
                             want.speed_x, want.speed_y, want.distance,
                             got.speed_x, got.speed_y, got.distance);
            end
        endfunction

        function int failures();
            return mismatches + unexpected + pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    frame_scoreboard sb = new();

    int cycles;
    int burst_left;
    int frame_items;
    int n_good;
    int n_bad_sum;
    int n_bad_hdr;
    int n_cut;
    int n_noise;

    sync_header_sum_checked_frame_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_rx_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(shscfp_pkg::result_t'(m_tdata));
    end

    // receiver back-pressure, pattern picked at random from four modes
    initial
    begin
        int mode;
        int phase;
        mode     = 0;
        phase    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase % 50 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((phase % 7) >= 4);
                default: m_tready <= ((phase % 32) >= 24);
            endcase
            phase++;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return shscfp_pkg::HDR_FIRST;
            5:       return shscfp_pkg::HDR_SECOND;
            default: return 8'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(60, 120);
            end
            else
            begin
                gap        = $urandom_range(0, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // csum_err of zero gives a good checksum
    task automatic send_frame(input logic [39:0] payload, input logic [7:0] csum_err);
        logic [7:0] csum;
        csum = shscfp_pkg::HDR_FIRST + shscfp_pkg::HDR_SECOND;
        send_byte(shscfp_pkg::HDR_FIRST);
        send_byte(shscfp_pkg::HDR_SECOND);
        for (int i = 0; i < 5; i++)
        begin
            csum = csum + payload[8*i +: 8];
            send_byte(payload[8*i +: 8]);
        end
        send_byte(csum + csum_err);
        frame_items += 8;
        if (csum_err == 8'h00)
            n_good++;
        else
            n_bad_sum++;
    endtask

    function automatic logic [39:0] pick_payload();
        logic [39:0] p;
        for (int i = 0; i < 5; i++)
            p[8*i +: 8] = pick_byte();
        return p;
    endfunction

    initial
    begin
        int         n;
        logic [7:0] hdr2;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        rst_n       = 1'b0;
        cycles      = 0;
        burst_left  = 0;
        frame_items = 0;
        n_good      = 0;
        n_bad_sum   = 0;
        n_bad_hdr   = 0;
        n_cut       = 0;
        n_noise     = 0;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // noise while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        // extremes: speed_x -128, speed_y 127, distance 0x0000
        send_frame({8'h00, 8'h00, 8'hFF, 8'h7F, 8'h80}, 8'h00);
        // bad second header; the repeated header byte must not restart the frame
        send_byte(shscfp_pkg::HDR_FIRST);
        send_byte(shscfp_pkg::HDR_FIRST);
        send_byte(shscfp_pkg::HDR_SECOND);
        n_bad_hdr++;
        // bad checksum, dropped
        send_frame({8'h12, 8'h34, 8'h56, 8'h01, 8'hFE}, 8'h01);
        // extremes: speed_x 127, speed_y -128, distance 0xFFFF
        send_frame({8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F}, 8'h00);

        while (frame_items < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1:
                    send_frame(pick_payload(), 8'($urandom_range(1, 255)));
                2, 3:
                begin
                    hdr2 = pick_byte();
                    if (hdr2 == shscfp_pkg::HDR_SECOND)
                        hdr2 = 8'h00;
                    send_byte(shscfp_pkg::HDR_FIRST);
                    send_byte(hdr2);
                    frame_items += 2;
                    n_bad_hdr++;
                end
                4:
                begin
                    // frame cut short; next bytes land in its payload
                    n = $urandom_range(0, 4);
                    send_byte(shscfp_pkg::HDR_FIRST);
                    send_byte(shscfp_pkg::HDR_SECOND);
                    repeat (n) send_byte(pick_byte());
                    frame_items += 2 + n;
                    n_cut++;
                end
                5, 6:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom));
                    n_noise += n;
                end
                default:
                    send_frame(pick_payload(), 8'h00);
            endcase
        end

        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d frame items plus %0d noise bytes: %0d good, %0d bad-checksum,",
                 frame_items, n_noise, n_good, n_bad_sum);
        $display("%0d bad-header and %0d truncated frames; %0d results checked, %0d failures",
                 n_bad_hdr, n_cut, sb.checked, sb.failures());
        if (sb.failures() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/shscfp_pkg.sv
rtl/shscfp_core.sv
rtl/sync_header_sum_checked_frame_parser.sv
test/tb_top.sv
